// ----- rtl/core/map_range_interpolate_top_macros.svh -----
// Assertion macros shared by the map range interpolate RTL.
`ifndef MAP_RANGE_INTERPOLATE_TOP_MACROS_SVH
`define MAP_RANGE_INTERPOLATE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MRI_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MRI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MRI_ASSERT_IMPLY(lbl, ante, cons, msg)
`define MRI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/mri_pkg.sv -----
// Types, constants and saturation helpers for the map range interpolate block.
package mri_pkg;

    localparam int DIV_N    = 48;
    localparam int DIV_D    = 32;
    localparam int DIV_LAT  = DIV_N + 1;
    localparam int FRNT_LAT = 1;
    localparam int SHP_LAT  = 4;
    localparam int FIN_LAT  = 5;

    localparam logic [1:0] OP_LINEAR   = 2'd0;
    localparam logic [1:0] OP_STEPPED  = 2'd1;
    localparam logic [1:0] OP_SMOOTH   = 2'd2;
    localparam logic [1:0] OP_SMOOTHER = 2'd3;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         mode;
        logic               do_clamp;
        logic               vec;
        logic               range_nz;
        logic signed [31:0] steps;
        logic signed [31:0] s1;
        logic signed [31:0] tgt_lo;
        logic signed [31:0] tgt_hi;
        logic signed [31:0] tgt_range;
    } side_t;

    // saturate a 33 bit sum or difference to Q16.16
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? Q_MIN : Q_MAX;
        else
            r = v[31:0];
        return r;
    endfunction

    // saturate a 48 bit value to Q16.16
    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if ((&v[47:31]) || !(|v[47:31]))
            r = v[31:0];
        else
            r = v[47] ? Q_MIN : Q_MAX;
        return r;
    endfunction

    // magnitude of a signed 32 bit value
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

    // apply sign to a quotient magnitude and saturate
    function automatic logic signed [31:0] sat_quot(input logic [47:0] q, input logic neg);
        logic signed [31:0] r;
        if (neg)
            r = (q > 48'h0000_8000_0000) ? Q_MIN : (32'd0 - q[31:0]);
        else
            r = (q > 48'h0000_7FFF_FFFF) ? Q_MAX : q[31:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/mri_divider.sv -----
// Pipelined radix-2 restoring divider, one quotient bit per stage.
`include "map_range_interpolate_top_macros.svh"
module mri_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [47:0]        in_num,
    input  logic [31:0]        in_den,
    input  logic               in_neg,
    input  mri_pkg::side_t     in_side,
    input  logic signed [31:0] in_aux,
    output logic               out_valid,
    output logic [47:0]        out_quot,
    output logic               out_neg,
    output mri_pkg::side_t     out_side,
    output logic signed [31:0] out_aux
);
    import mri_pkg::*;

    logic [DIV_N:0]     vld_reg;
    logic [DIV_D-1:0]   rem_reg  [0:DIV_N];
    logic [DIV_N-1:0]   dq_reg   [0:DIV_N];
    logic [DIV_D-1:0]   den_reg  [0:DIV_N];
    logic               neg_reg  [0:DIV_N];
    side_t              side_reg [0:DIV_N];
    logic signed [31:0] aux_reg  [0:DIV_N];

    logic [DIV_D:0]     trial    [0:DIV_N-1];
    logic               qbit     [0:DIV_N-1];
    logic [DIV_D-1:0]   rem_next [0:DIV_N-1];
    logic [DIV_N-1:0]   dq_next  [0:DIV_N-1];

    // shift in one dividend bit, subtract when the divisor fits
    always_comb
    begin
        for (int k = 0; k < DIV_N; k++)
        begin
            trial[k] = {rem_reg[k], dq_reg[k][DIV_N-1]};
            qbit[k]  = trial[k] >= {1'b0, den_reg[k]};
            if (qbit[k])
                rem_next[k] = DIV_D'(trial[k] - {1'b0, den_reg[k]});
            else
                rem_next[k] = trial[k][DIV_D-1:0];
            dq_next[k] = {dq_reg[k][DIV_N-2:0], qbit[k]};
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[DIV_N-1:0], in_valid};
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        dq_reg[0]   <= in_num;
        den_reg[0]  <= in_den;
        neg_reg[0]  <= in_neg;
        side_reg[0] <= in_side;
        aux_reg[0]  <= in_aux;
        for (int k = 0; k < DIV_N; k++)
        begin
            rem_reg[k+1]  <= rem_next[k];
            dq_reg[k+1]   <= dq_next[k];
            den_reg[k+1]  <= den_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            side_reg[k+1] <= side_reg[k];
            aux_reg[k+1]  <= aux_reg[k];
        end
    end

    assign out_valid = vld_reg[DIV_N];
    assign out_quot  = dq_reg[DIV_N];
    assign out_neg   = neg_reg[DIV_N];
    assign out_side  = side_reg[DIV_N];
    assign out_aux   = aux_reg[DIV_N];

    `MRI_ASSERT_IMPLY(a_div_rem, vld_reg[DIV_N], rem_reg[DIV_N] < den_reg[DIV_N], "divider remainder not below divisor")
    `MRI_ASSERT_IMPLY(a_div_lat, vld_reg[DIV_N], $past(in_valid, DIV_N + 1), "divider result without request")

endmodule

// ----- rtl/core/mri_shaper.sv -----
// Factor shaping pipeline: linear, step quantize, smoothstep, smootherstep.
module mri_shaper
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [47:0]        in_quot,
    input  logic               in_neg,
    input  mri_pkg::side_t     in_side,
    output logic               out_valid,
    output logic [47:0]        out_num,
    output logic [31:0]        out_den,
    output logic               out_neg,
    output mri_pkg::side_t     out_side,
    output logic signed [31:0] out_aux
);
    import mri_pkg::*;

    logic [3:0]         vld_reg;
    side_t              side0_reg, side1_reg, side2_reg, side3_reg;
    logic signed [31:0] f0_reg, f1_reg, f2_reg, f3_reg;
    logic signed [63:0] p1_reg;
    logic [16:0]        c1_reg;
    logic [33:0]        cc1_reg;
    logic signed [39:0] ca1_reg;
    logic signed [15:0] t2_reg, t3_reg;
    logic [34:0]        m2_reg;
    logic [33:0]        ccc2_reg;
    logic signed [23:0] b2_reg;
    logic [16:0]        smooth3_reg;
    logic [36:0]        pr3_reg;

    logic signed [31:0] f0_next;
    logic [16:0]        c_next;
    logic signed [21:0] a_next;
    logic signed [31:0] pt_next;
    logic signed [15:0] t_next;
    logic [16:0]        c2_next;
    logic [17:0]        w_next;
    logic [16:0]        c3_next;
    logic [20:0]        smoother_next;
    logic signed [31:0] shaped_next;
    logic               steps_pos;

    // sign and saturate the factor, zero when the source range is empty
    assign f0_next = in_side.range_nz ? sat_quot(in_quot, in_neg) : 32'sd0;

    // clamp factor to [0, 1] for the smooth modes
    always_comb
    begin
        if (f0_reg[31])
            c_next = '0;
        else if (f0_reg > Q_ONE)
            c_next = 17'h1_0000;
        else
            c_next = f0_reg[16:0];
        a_next = $signed({5'b0, c_next}) * 22'sd6 - 22'sd983040;
    end

    // floor step index and saturate to 16 bits
    always_comb
    begin
        pt_next = p1_reg[63:32];
        if (pt_next > 32'sd32767)
            t_next = 16'sh7FFF;
        else if (pt_next < -32'sd32768)
            t_next = 16'sh8000;
        else
            t_next = pt_next[15:0];
        c2_next = cc1_reg[32:16];
        w_next  = 18'd196608 - {c1_reg, 1'b0};
    end

    assign c3_next       = ccc2_reg[32:16];
    assign smoother_next = pr3_reg[36:16];

    // select the shaped factor
    always_comb
    begin
        unique case (side3_reg.mode)
            OP_LINEAR:   shaped_next = f3_reg;
            OP_STEPPED:  shaped_next = f3_reg;
            OP_SMOOTH:   shaped_next = $signed({15'b0, smooth3_reg});
            OP_SMOOTHER: shaped_next = $signed({11'b0, smoother_next});
            default:     shaped_next = f3_reg;
        endcase
    end

    assign steps_pos = !side3_reg.steps[31] && (|side3_reg.steps);

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[2:0], in_valid};
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        side0_reg   <= in_side;
        f0_reg      <= f0_next;

        side1_reg   <= side0_reg;
        f1_reg      <= f0_reg;
        p1_reg      <= f0_reg * side0_reg.s1;
        c1_reg      <= c_next;
        cc1_reg     <= c_next * c_next;
        ca1_reg     <= $signed({1'b0, c_next}) * a_next;

        side2_reg   <= side1_reg;
        f2_reg      <= f1_reg;
        t2_reg      <= t_next;
        m2_reg      <= w_next * c2_next;
        ccc2_reg    <= c2_next * c1_reg;
        b2_reg      <= ca1_reg[39:16] + 24'sd655360;

        side3_reg   <= side2_reg;
        f3_reg      <= f2_reg;
        t3_reg      <= t2_reg;
        smooth3_reg <= m2_reg[32:16];
        pr3_reg     <= c3_next * b2_reg[19:0];
    end

    // build the step quotient request
    assign out_valid = vld_reg[3];
    assign out_num   = {(t3_reg[15] ? 16'(~t3_reg + 16'd1) : t3_reg), 32'b0};
    assign out_den   = steps_pos ? side3_reg.steps : 32'd1;
    assign out_neg   = t3_reg[15];
    assign out_side  = side3_reg;
    assign out_aux   = shaped_next;

endmodule

// ----- rtl/core/mri_finish.sv -----
// Final scale into the target range, zero-range rule and clamp.
`include "map_range_interpolate_top_macros.svh"
module mri_finish
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [47:0]        in_quot,
    input  logic               in_neg,
    input  mri_pkg::side_t     in_side,
    input  logic signed [31:0] in_aux,
    output logic               done,
    output logic signed [31:0] mapped
);
    import mri_pkg::*;

    logic               e_vld_reg, f_vld_reg, g_vld_reg, h_vld_reg, done_reg;
    side_t              e_side_reg, f_side_reg, g_side_reg;
    logic signed [31:0] e_f_reg;
    logic signed [63:0] f_prod_reg;
    logic signed [31:0] g_qm_reg;
    logic signed [31:0] h_sum_reg, h_lo_reg, h_hi_reg;
    logic               h_clamp_reg;
    logic signed [31:0] mapped_reg;

    logic               steps_pos;
    logic signed [31:0] f_next;
    logic signed [31:0] sum_next;
    logic signed [31:0] res_next;

    // pick the step quotient in stepped mode
    assign steps_pos = !in_side.steps[31] && (|in_side.steps);
    always_comb
    begin
        if (in_side.mode == OP_STEPPED)
            f_next = steps_pos ? sat_quot(in_quot, in_neg) : 32'sd0;
        else
            f_next = in_aux;
    end

    // offset by target start, force zero under scalar rules on empty range
    always_comb
    begin
        sum_next = sat33({g_side_reg.tgt_lo[31], g_side_reg.tgt_lo} + {g_qm_reg[31], g_qm_reg});
        if (!g_side_reg.vec && !g_side_reg.range_nz)
            sum_next = '0;
    end

    // clamp into the target bounds
    always_comb
    begin
        priority if (h_clamp_reg && (h_sum_reg < h_lo_reg))
            res_next = h_lo_reg;
        else if (h_clamp_reg && (h_sum_reg > h_hi_reg))
            res_next = h_hi_reg;
        else
            res_next = h_sum_reg;
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            e_vld_reg <= in_valid;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
            h_vld_reg <= g_vld_reg;
            done_reg  <= h_vld_reg;
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        e_side_reg  <= in_side;
        e_f_reg     <= f_next;
        f_side_reg  <= e_side_reg;
        f_prod_reg  <= e_f_reg * e_side_reg.tgt_range;
        g_side_reg  <= f_side_reg;
        g_qm_reg    <= sat48(f_prod_reg[63:16]);
        h_sum_reg   <= sum_next;
        h_lo_reg    <= (g_side_reg.tgt_lo < g_side_reg.tgt_hi) ? g_side_reg.tgt_lo
                                                               : g_side_reg.tgt_hi;
        h_hi_reg    <= (g_side_reg.tgt_lo < g_side_reg.tgt_hi) ? g_side_reg.tgt_hi
                                                               : g_side_reg.tgt_lo;
        h_clamp_reg <= g_side_reg.do_clamp && (!g_side_reg.vec || !g_side_reg.mode[1]);
        mapped_reg  <= res_next;
    end

    assign done   = done_reg;
    assign mapped = mapped_reg;

    `MRI_ASSERT_NEXT(a_fin_clamp, h_vld_reg && h_clamp_reg, done_reg && (mapped_reg >= $past(h_lo_reg)) && (mapped_reg <= $past(h_hi_reg)), "clamped result outside target bounds")

endmodule

// ----- rtl/core/map_range_interpolate_top.sv -----
// Top level of the map range interpolate pipeline.
// Remaps one signed Q16.16 value per request from a source range to a target range with
// linear, stepped, smoothstep or smootherstep shaping and an optional clamp. A request is
// taken at every clock edge with start high; busy is always low, so one request per cycle
// is sustained. Each result appears on mapped with done high for one cycle, in request
// order; the receiver cannot stall. The path runs through two 48-stage radix-2 divider
// pipelines (factor quotient and step quotient) plus the front, shaping and scaling stages.
`include "map_range_interpolate_top_macros.svh"
module map_range_interpolate_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] value,
    input  logic signed [31:0] source_low,
    input  logic signed [31:0] source_high,
    input  logic signed [31:0] target_low,
    input  logic signed [31:0] target_high,
    input  logic signed [31:0] step_count,
    input  logic [1:0]         opcode,
    input  logic               clamp_enable,
    input  logic               vector_rules,
    output logic               done,
    output logic signed [31:0] mapped
);
    import mri_pkg::*;

    localparam int TOTAL_LAT = FRNT_LAT + DIV_LAT + SHP_LAT + DIV_LAT + FIN_LAT;

    logic               a_vld_reg;
    logic signed [31:0] a_num_reg, a_den_reg;
    side_t              a_side_reg;

    logic signed [31:0] den_next;
    side_t              side_next;

    logic               d1_valid;
    logic [47:0]        d1_quot;
    logic               d1_neg;
    side_t              d1_side;
    logic signed [31:0] d1_aux;

    logic               sh_valid;
    logic [47:0]        sh_num;
    logic [31:0]        sh_den;
    logic               sh_neg;
    side_t              sh_side;
    logic signed [31:0] sh_aux;

    logic               d2_valid;
    logic [47:0]        d2_quot;
    logic               d2_neg;
    side_t              d2_side;
    logic signed [31:0] d2_aux;

    // form range differences and request side data
    always_comb
    begin
        den_next            = sat33({source_high[31], source_high} - {source_low[31], source_low});
        side_next.mode      = opcode;
        side_next.do_clamp  = clamp_enable;
        side_next.vec       = vector_rules;
        side_next.range_nz  = |den_next;
        side_next.steps     = step_count;
        side_next.s1        = sat33({step_count[31], step_count} + 33'sh0_0001_0000);
        side_next.tgt_lo    = target_low;
        side_next.tgt_hi    = target_high;
        side_next.tgt_range = sat33({target_high[31], target_high}
                                    - {target_low[31], target_low});
    end

    // hold the front stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        a_num_reg  <= sat33({value[31], value} - {source_low[31], source_low});
        a_den_reg  <= den_next;
        a_side_reg <= side_next;
    end

    assign busy = 1'b0;

    mri_divider u_div_factor
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_vld_reg),
        .in_num    ({mag32(a_num_reg), 16'b0}),
        .in_den    (a_side_reg.range_nz ? mag32(a_den_reg) : 32'd1),
        .in_neg    (a_num_reg[31] ^ a_den_reg[31]),
        .in_side   (a_side_reg),
        .in_aux    (32'sd0),
        .out_valid (d1_valid),
        .out_quot  (d1_quot),
        .out_neg   (d1_neg),
        .out_side  (d1_side),
        .out_aux   (d1_aux)
    );

    mri_shaper u_shaper
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid),
        .in_quot   (d1_quot),
        .in_neg    (d1_neg),
        .in_side   (d1_side),
        .out_valid (sh_valid),
        .out_num   (sh_num),
        .out_den   (sh_den),
        .out_neg   (sh_neg),
        .out_side  (sh_side),
        .out_aux   (sh_aux)
    );

    mri_divider u_div_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sh_valid),
        .in_num    (sh_num),
        .in_den    (sh_den),
        .in_neg    (sh_neg),
        .in_side   (sh_side),
        .in_aux    (sh_aux),
        .out_valid (d2_valid),
        .out_quot  (d2_quot),
        .out_neg   (d2_neg),
        .out_side  (d2_side),
        .out_aux   (d2_aux)
    );

    mri_finish u_finish
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (d2_valid),
        .in_quot  (d2_quot),
        .in_neg   (d2_neg),
        .in_side  (d2_side),
        .in_aux   (d2_aux),
        .done     (done),
        .mapped   (mapped)
    );

    `MRI_ASSERT_IMPLY(a_top_lat, done, $past(start, TOTAL_LAT), "result without matching request")
    `MRI_ASSERT_IMPLY(a_top_aux, d1_valid, d1_aux == 32'sd0, "factor divider side data corrupted")

endmodule
